// File: rtl/gwps_pkg.sv
`default_nettype none

package gwps_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int MAX_WORD   = 16;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int CELL_W  = 8;
	localparam int SYM_W   = 8;
	localparam int DIM_W   = 5;
	localparam int WORD_IW = $clog2(MAX_WORD);
	localparam int DEPTH_W = WORD_IW + 1;
	localparam int DIR_W   = 3;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [DIR_W-1:0]  dir_t;

	localparam logic [1:0] CMD_CELL   = 2'd0;
	localparam logic [1:0] CMD_CHAR   = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	localparam logic [7:0] REG_ROWS = 8'd0;
	localparam logic [7:0] REG_COLS = 8'd1;

	localparam dir_t DIR_DOWN  = 3'd0;
	localparam dir_t DIR_UP    = 3'd1;
	localparam dir_t DIR_RIGHT = 3'd2;
	localparam dir_t DIR_LEFT  = 3'd3;
	localparam dir_t DIR_DONE  = 3'd4;

endpackage

`default_nettype wire

// File: rtl/grid_word_path_search_top.sv
// Grid word path search.
// The request channel (in_valid, in_stall) carries cmd, slot, symbol and
// word_length. A cell write or a word character write gives no result. A
// search request answers on the result channel (out_valid, out_stall) with
// one found bit.
// A search holds in_stall high while it walks. Each start cell tried takes
// a read state and a compare state, a neighbor probe that stays inside the
// grid and off the path takes a step state and a check state, and a rejected
// probe, a pop or a restart of the scan takes only a step state, all set by
// the single read port of the grid memory. A search with word length zero
// goes straight to the finish state to raise out_valid. The result sits
// in an output register, so load requests are taken while a result waits.
// A search that finishes while the previous result is still stalled waits
// until that result is taken. The configuration channel (cfg_valid,
// cfg_ready) writes grid_rows at index 0 and grid_cols at index 1; it is
// always ready. The user is to use it only while idle; the block does not
// enforce this. Reset sets both dimensions to 16 and empties the result
// register. Grid and word contents are undefined until written.
`default_nettype none

module grid_word_path_search_top
	import gwps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         slot,
	input  wire logic [SYM_W-1:0]   symbol,
	input  wire logic [DEPTH_W-1:0] word_length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN_RD  = 3'd1;
	localparam logic [2:0] ST_SCAN_CMP = 3'd2;
	localparam logic [2:0] ST_STEP     = 3'd3;
	localparam logic [2:0] ST_CHECK    = 3'd4;
	localparam logic [2:0] ST_FINISH   = 3'd5;

	logic [2:0]         state_q;
	logic [DIM_W-1:0]   rows_q;
	logic [DIM_W-1:0]   cols_q;
	logic [DEPTH_W-1:0] len_q;
	logic [ROW_W-1:0]   scan_r_q;
	logic [COL_W-1:0]   scan_c_q;
	logic [DEPTH_W-1:0] path_depth_q;
	cell_t              next_cell_q;
	logic               hit_q;
	logic               out_valid_q;
	logic               found_q;

	cell_t path_cell_q [MAX_WORD];
	dir_t  path_dir_q [MAX_WORD];
	sym_t  word_q [MAX_WORD];
	sym_t  grid_mem [CELL_COUNT];
	sym_t  grid_rd_q;

	logic         in_fire;
	logic         cfg_fire;
	logic         grid_we;
	cell_t        grid_raddr;
	logic         scan_last;
	logic [WORD_IW-1:0] top_idx;
	cell_t        top_cell;
	dir_t         top_dir;
	logic [ROW_W-1:0] top_r;
	logic [COL_W-1:0] top_c;
	logic         nb_ok;
	cell_t        nb_cell;
	logic         nb_visited;
	logic [DIM_W-1:0] cfg_clamped;

	assign in_fire   = in_valid && !in_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;

	assign grid_we   = in_fire && (cmd == CMD_CELL) && (9'(slot) < 9'(CELL_COUNT));
	assign scan_last = ({1'b0, scan_r_q} == rows_q - DIM_W'(1))
		&& ({1'b0, scan_c_q} == cols_q - DIM_W'(1));

	assign top_idx  = WORD_IW'(path_depth_q - DEPTH_W'(1));
	assign top_cell = path_cell_q[top_idx];
	assign top_dir  = path_dir_q[top_idx];
	assign top_r    = top_cell[CELL_W-1:COL_W];
	assign top_c    = top_cell[COL_W-1:0];

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = DIM_W'(1);
		end else if (cfg_data > DIM_W'(MAX_ROWS)) begin
			cfg_clamped = DIM_W'(MAX_ROWS);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_comb begin
		nb_ok   = 1'b0;
		nb_cell = top_cell;
		case (top_dir)
			DIR_DOWN: begin
				nb_ok   = ({1'b0, top_r} + DIM_W'(1)) < rows_q;
				nb_cell = {ROW_W'(top_r + ROW_W'(1)), top_c};
			end
			DIR_UP: begin
				nb_ok   = (top_r != '0);
				nb_cell = {ROW_W'(top_r - ROW_W'(1)), top_c};
			end
			DIR_RIGHT: begin
				nb_ok   = ({1'b0, top_c} + DIM_W'(1)) < cols_q;
				nb_cell = {top_r, COL_W'(top_c + COL_W'(1))};
			end
			DIR_LEFT: begin
				nb_ok   = (top_c != '0);
				nb_cell = {top_r, COL_W'(top_c - COL_W'(1))};
			end
			default: begin
				nb_ok   = 1'b0;
				nb_cell = top_cell;
			end
		endcase
	end

	// A cell is in use exactly when it is on the current path.
	always_comb begin
		nb_visited = 1'b0;
		for (int i = 0; i < MAX_WORD; i++) begin
			if ((DEPTH_W'(i) < path_depth_q) && (path_cell_q[i] == nb_cell)) begin
				nb_visited = 1'b1;
			end
		end
	end

	always_comb begin
		if (state_q == ST_STEP) begin
			grid_raddr = nb_cell;
		end else begin
			grid_raddr = {scan_r_q, scan_c_q};
		end
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[slot[CELL_W-1:0]] <= symbol;
		end
		grid_rd_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_fire && (cmd == CMD_CHAR) && (9'(slot) < 9'(MAX_WORD))) begin
			word_q[slot[WORD_IW-1:0]] <= symbol;
		end
		unique case (state_q)
			ST_SCAN_CMP: begin
				path_cell_q[0] <= {scan_r_q, scan_c_q};
				path_dir_q[0]  <= DIR_DOWN;
			end
			ST_STEP: begin
				if ((path_depth_q != '0) && (path_depth_q < len_q) && (top_dir < DIR_DONE)) begin
					path_dir_q[top_idx] <= dir_t'(top_dir + DIR_W'(1));
					next_cell_q         <= nb_cell;
				end
			end
			ST_CHECK: begin
				path_cell_q[path_depth_q[WORD_IW-1:0]] <= next_cell_q;
				path_dir_q[path_depth_q[WORD_IW-1:0]]  <= DIR_DOWN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rows_q       <= DIM_W'(MAX_ROWS);
			cols_q       <= DIM_W'(MAX_COLS);
			len_q        <= '0;
			scan_r_q     <= '0;
			scan_c_q     <= '0;
			path_depth_q <= '0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				if (cfg_index == REG_ROWS) begin
					rows_q <= cfg_clamped;
				end else if (cfg_index == REG_COLS) begin
					cols_q <= cfg_clamped;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (cmd == CMD_SEARCH)) begin
						scan_r_q     <= '0;
						scan_c_q     <= '0;
						path_depth_q <= '0;
						hit_q        <= 1'b0;
						if (word_length > DEPTH_W'(MAX_WORD)) begin
							len_q <= DEPTH_W'(MAX_WORD);
						end else begin
							len_q <= word_length;
						end
						if (word_length == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (grid_rd_q == word_q[0]) begin
						path_depth_q <= DEPTH_W'(1);
						state_q      <= ST_STEP;
					end else if (scan_last) begin
						state_q <= ST_FINISH;
					end else begin
						if ({1'b0, scan_c_q} == cols_q - DIM_W'(1)) begin
							scan_c_q <= '0;
							scan_r_q <= ROW_W'(scan_r_q + ROW_W'(1));
						end else begin
							scan_c_q <= COL_W'(scan_c_q + COL_W'(1));
						end
						state_q <= ST_SCAN_RD;
					end
				end
				ST_STEP: begin
					if (path_depth_q == '0) begin
						if (scan_last) begin
							state_q <= ST_FINISH;
						end else begin
							if ({1'b0, scan_c_q} == cols_q - DIM_W'(1)) begin
								scan_c_q <= '0;
								scan_r_q <= ROW_W'(scan_r_q + ROW_W'(1));
							end else begin
								scan_c_q <= COL_W'(scan_c_q + COL_W'(1));
							end
							state_q <= ST_SCAN_RD;
						end
					end else if (path_depth_q >= len_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (top_dir >= DIR_DONE) begin
						path_depth_q <= DEPTH_W'(path_depth_q - DEPTH_W'(1));
					end else if (nb_ok && !nb_visited) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (grid_rd_q == word_q[path_depth_q[WORD_IW-1:0]]) begin
						path_depth_q <= DEPTH_W'(path_depth_q + DEPTH_W'(1));
					end
					state_q <= ST_STEP;
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						found_q      <= hit_q;
						path_depth_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		path_depth_q <= DEPTH_W'(MAX_WORD))
		else $error("path depth beyond word capacity");
	a_check_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ($past(state_q) == ST_STEP) && (path_depth_q != '0))
		else $error("neighbor check without a probe");
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result raised outside finish");
	a_busy_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> in_stall)
		else $error("request taken during a search");
`endif

endmodule

`default_nettype wire

// File: tb/sv/grid_word_path_search_top_tb.sv
`timescale 1ns / 1ps

module grid_word_path_search_top_tb
	import gwps_pkg::*;
();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] REG_SPARE  = 8'd2;
	localparam logic [7:0] REG_LAST   = 8'hFF;
	localparam sym_t DASH = "-";
	localparam int RANDOM_PHASES  = 20;
	localparam int PHASE_REQUESTS = 30;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         slot;
		sym_t               symbol;
		logic [DEPTH_W-1:0] word_length;
	} request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_CELL;
	logic [7:0]         slot = '0;
	sym_t               symbol = '0;
	logic [DEPTH_W-1:0] word_length = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_index = '0;
	logic [DIM_W-1:0]   cfg_data = '0;

	grid_word_path_search_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.slot(slot),
		.symbol(symbol),
		.word_length(word_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	request_t pending[$];
	bit expected_found[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int requests_taken = 0;
	int searches_done = 0;
	int words_found = 0;
	int reg_writes = 0;
	int planned = 0;

	// Predicted contents of the block.
	sym_t grid_copy[CELL_COUNT];
	sym_t word_copy[MAX_WORD];
	int unsigned rows_in_use = MAX_ROWS;
	int unsigned cols_in_use = MAX_COLS;

	// What the stimulus has written so far, used to shape words and searches.
	sym_t plan_grid[CELL_COUNT];
	bit plan_word_set[MAX_WORD];
	int unsigned plan_rows = MAX_ROWS;
	int unsigned plan_cols = MAX_COLS;
	sym_t alpha_base = "A";
	int unsigned alpha_size = 1;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
			input int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// Depth-first walk with an explicit path stack and a visited bit per grid position.
	function automatic bit word_traceable(input logic [DEPTH_W-1:0] wlen);
		bit seen[CELL_COUNT];
		int unsigned stk_pos[MAX_WORD];
		dir_t stk_dir[MAX_WORD];
		int unsigned len, depth, lvl, r, c, nxt, sr, sc;
		dir_t dir;
		bit ok;
		len = (wlen > MAX_WORD) ? MAX_WORD : wlen;
		if (len == 0)
			return 1'b0;
		for (sr = 0; sr < rows_in_use; sr++) begin
			for (sc = 0; sc < cols_in_use; sc++) begin
				nxt = sr * MAX_COLS + sc;
				if (grid_copy[nxt] != word_copy[0])
					continue;
				stk_pos[0] = nxt;
				stk_dir[0] = DIR_DOWN;
				seen[nxt] = 1'b1;
				depth = 1;
				while (depth > 0) begin
					if (depth >= len)
						return 1'b1;
					lvl = depth - 1;
					dir = stk_dir[lvl];
					if (dir == DIR_DONE) begin
						seen[stk_pos[lvl]] = 1'b0;
						depth--;
						continue;
					end
					stk_dir[lvl] = dir + dir_t'(1);
					r = stk_pos[lvl] / MAX_COLS;
					c = stk_pos[lvl] % MAX_COLS;
					ok = 1'b1;
					case (dir)
						DIR_DOWN:  if (r + 1 < rows_in_use) r++; else ok = 1'b0;
						DIR_UP:    if (r > 0) r--; else ok = 1'b0;
						DIR_RIGHT: if (c + 1 < cols_in_use) c++; else ok = 1'b0;
						default:   if (c > 0) c--; else ok = 1'b0;
					endcase
					if (!ok)
						continue;
					nxt = r * MAX_COLS + c;
					if (seen[nxt] || grid_copy[nxt] != word_copy[depth])
						continue;
					stk_pos[depth] = nxt;
					stk_dir[depth] = DIR_DOWN;
					seen[nxt] = 1'b1;
					depth++;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic apply_request(input request_t rq);
		case (rq.cmd)
			CMD_CELL: begin
				if (rq.slot < CELL_COUNT)
					grid_copy[rq.slot] = rq.symbol;
			end
			CMD_CHAR: begin
				if (rq.slot < MAX_WORD)
					word_copy[rq.slot] = rq.symbol;
			end
			CMD_SEARCH: begin
				expected_found.insert(expected_found.size(),
					word_traceable(rq.word_length));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				slot <= nxt.slot;
				symbol <= nxt.symbol;
				word_length <= nxt.word_length;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_results
		request_t seen_rq;
		bit want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				if (cfg_index == REG_ROWS)
					rows_in_use = clamp_dim(cfg_data, MAX_ROWS);
				else if (cfg_index == REG_COLS)
					cols_in_use = clamp_dim(cfg_data, MAX_COLS);
			end
			if (in_valid && !in_stall) begin
				seen_rq.cmd = cmd;
				seen_rq.slot = slot;
				seen_rq.symbol = symbol;
				seen_rq.word_length = word_length;
				requests_taken++;
				apply_request(seen_rq);
			end
			if (out_valid && !out_stall) begin
				if (expected_found.size() == 0) begin
					errors++;
					$display("%0t: result with no search pending, expected none, got found=%0b",
						$time, found);
				end else begin
					want = expected_found.pop_front();
					searches_done++;
					if (want)
						words_found++;
					if (found !== want) begin
						errors++;
						$display("%0t: found mismatch, expected %0b, got %0b",
							$time, want, found);
					end
				end
			end
		end
	end

	task automatic queue_request(input logic [1:0] c, input logic [7:0] s, input sym_t sy,
			input logic [DEPTH_W-1:0] wl);
		request_t rq;
		rq.cmd = c;
		rq.slot = s;
		rq.symbol = sy;
		rq.word_length = wl;
		pending.insert(pending.size(), rq);
		planned++;
		if (c == CMD_CELL && s < CELL_COUNT)
			plan_grid[s] = sy;
		if (c == CMD_CHAR && s < MAX_WORD)
			plan_word_set[s] = 1'b1;
	endtask

	task automatic write_cell(input logic [7:0] s, input sym_t sy);
		queue_request(CMD_CELL, s, sy, DEPTH_W'($urandom_range(31)));
	endtask

	task automatic write_char(input logic [7:0] s, input sym_t sy);
		queue_request(CMD_CHAR, s, sy, DEPTH_W'($urandom_range(31)));
	endtask

	function automatic sym_t pick_symbol();
		if ($urandom_range(15) == 0)
			return DASH;
		return alpha_base + sym_t'($urandom_range(alpha_size - 1));
	endfunction

	function automatic int unsigned pick_length();
		if ($urandom_range(7) == 0)
			return $urandom_range(1, 31);
		return $urandom_range(1, 6);
	endfunction

	// Every word position the search will read gets written first.
	task automatic request_search(input int unsigned len);
		int unsigned need, i;
		need = (len > MAX_WORD) ? MAX_WORD : len;
		for (i = 0; i < need; i++) begin
			if (!plan_word_set[i])
				write_char(8'(i), pick_symbol());
		end
		queue_request(CMD_SEARCH, 8'($urandom), 8'($urandom), DEPTH_W'(len));
	endtask

	task automatic fill_region();
		int unsigned r, c;
		for (r = 0; r < plan_rows; r++) begin
			for (c = 0; c < plan_cols; c++)
				write_cell(8'(r * MAX_COLS + c), pick_symbol());
		end
	endtask

	// Takes a random self-avoiding walk through the region and searches for the
	// word read along it, optionally with one bit of one character flipped.
	task automatic trace_word(input int unsigned want, input bit broken);
		bit used[CELL_COUNT];
		logic [7:0] path[MAX_WORD];
		logic [7:0] opts[4];
		int unsigned steps, n, r, c, i, bad;
		sym_t sy;
		steps = (want > MAX_WORD) ? MAX_WORD : want;
		path[0] = 8'($urandom_range(plan_rows - 1) * MAX_COLS
			+ $urandom_range(plan_cols - 1));
		used[path[0]] = 1'b1;
		for (i = 1; i < steps; i++) begin
			r = path[i-1] / MAX_COLS;
			c = path[i-1] % MAX_COLS;
			n = 0;
			if (r + 1 < plan_rows && !used[path[i-1] + MAX_COLS]) begin
				opts[n] = 8'(path[i-1] + MAX_COLS);
				n++;
			end
			if (r > 0 && !used[path[i-1] - MAX_COLS]) begin
				opts[n] = 8'(path[i-1] - MAX_COLS);
				n++;
			end
			if (c + 1 < plan_cols && !used[path[i-1] + 1]) begin
				opts[n] = 8'(path[i-1] + 1);
				n++;
			end
			if (c > 0 && !used[path[i-1] - 1]) begin
				opts[n] = 8'(path[i-1] - 1);
				n++;
			end
			if (n == 0)
				break;
			path[i] = opts[$urandom_range(n - 1)];
			used[path[i]] = 1'b1;
		end
		steps = i;
		bad = $urandom_range(steps - 1);
		for (i = 0; i < steps; i++) begin
			sy = plan_grid[path[i]];
			if (broken && i == bad)
				sy = sy ^ (sym_t'(1) << $urandom_range(7));
			write_char(8'(i), sy);
		end
		request_search((steps == MAX_WORD && want > MAX_WORD) ? want : steps);
	endtask

	task automatic write_register(input logic [7:0] idx, input logic [DIM_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS)
			plan_rows = clamp_dim(data, MAX_ROWS);
		else if (idx == REG_COLS)
			plan_cols = clamp_dim(data, MAX_COLS);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || expected_found.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int p, goal, wlen, i;
		int unsigned roll, raw_r, raw_c, area;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 33;
		recv_idle_pct = 61;
		@(negedge clk);

		// Two by three grid: A B - over FF 00 A.
		write_register(REG_ROWS, 5'd2);
		write_register(REG_COLS, 5'd3);
		write_register(REG_LAST, 5'd31);
		write_cell(8'd0, "A");
		write_cell(8'd1, "B");
		write_cell(8'd2, DASH);
		write_cell(8'd16, 8'hFF);
		write_cell(8'd17, 8'h00);
		write_cell(8'd18, "A");
		write_cell(8'd255, 8'h5A);
		queue_request(CMD_UNUSED, 8'hAA, 8'h55, 5'h15);
		write_char(8'd0, "A");
		write_char(8'd1, "B");
		write_char(8'd2, DASH);
		request_search(0);
		request_search(3);
		write_char(8'hFF, "Z");
		request_search(3);
		// The path may not come back to the starting A.
		write_char(8'd2, "A");
		request_search(3);
		// Only one dash in the grid, so a double dash must fail.
		write_char(8'd0, DASH);
		write_char(8'd1, DASH);
		request_search(2);
		request_search(1);
		write_char(8'd0, 8'hFF);
		write_char(8'd1, 8'h00);
		request_search(2);
		request_search(1);
		wait_idle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 7) begin
				send_idle_pct = 61;
				recv_idle_pct = 33;
			end
			if (p == 14) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: begin
					raw_r = 0;
					raw_c = 0;
				end
				1: begin
					raw_r = 31;
					raw_c = 1;
				end
				2: begin
					raw_r = 1;
					raw_c = 17;
				end
				3: begin
					raw_r = 16;
					raw_c = 16;
				end
				9: begin
					raw_r = 16;
					raw_c = 2;
				end
				default: begin
					raw_r = $urandom_range(1, 6);
					raw_c = $urandom_range(1, 6);
				end
			endcase
			write_register(REG_ROWS, DIM_W'(raw_r));
			write_register(REG_COLS, DIM_W'(raw_c));
			if ($urandom_range(2) == 0)
				write_register($urandom_range(1) ? REG_SPARE : REG_LAST, DIM_W'($urandom));
			area = plan_rows * plan_cols;
			if (area <= 9)
				alpha_size = $urandom_range(1, 3);
			else if (area <= 36)
				alpha_size = $urandom_range(3, 4);
			else
				alpha_size = $urandom_range(4, 6);
			alpha_base = sym_t'($urandom_range(250));
			fill_region();
			goal = planned + PHASE_REQUESTS;
			while (planned < goal) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					trace_word(pick_length(), 1'b0);
				end else if (roll < 60) begin
					trace_word(pick_length(), 1'b1);
				end else if (roll < 72) begin
					wlen = $urandom_range(1, 4);
					for (i = 0; i < wlen; i++)
						write_char(8'(i), sym_t'($urandom));
					request_search(wlen);
				end else if (roll < 77) begin
					request_search($urandom_range(1) ? 0 : $urandom_range(17, 31));
				end else if (roll < 85) begin
					queue_request(CMD_UNUSED, 8'($urandom), 8'($urandom),
						DEPTH_W'($urandom));
				end else if (roll < 92) begin
					write_char(8'($urandom_range(MAX_WORD, 255)), sym_t'($urandom));
				end else begin
					write_cell(8'($urandom), sym_t'($urandom));
				end
			end
			wait_idle();
		end

		repeat (16) @(negedge clk);
		$display("Run took %0d requests and checked %0d searches, %0d of them traced.",
			requests_taken, searches_done, words_found);
		$display("Grids from 1x1 to 16x16 over %0d register writes, %0d mismatches.",
			reg_writes, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d searches still pending.", expected_found.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/gwps_pkg.sv
rtl/grid_word_path_search_top.sv
tb/sv/grid_word_path_search_top_tb.sv
